// ===== hw/rtl/sbks_pkg.sv =====
package sbks_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int BYTE_W     = 8;
    localparam int STATE_W    = SLOT_COUNT * BYTE_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH = 8'd3;

    typedef logic [BYTE_W-1:0] byte_t;

    // step request toward the keystream unit
    typedef struct packed {
        logic advance;
        logic restart;
    } sbks_ctrl_t;

    // aes forward s-box
    localparam byte_t SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

endpackage

// ===== hw/rtl/sbks_cfg.sv =====
module sbks_cfg
    import sbks_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output logic [STATE_W-1:0]    load_state
);

    logic [CFG_DATA_W-1:0] key_low_reg;
    logic [CFG_DATA_W-1:0] key_high_reg;
    logic [CFG_DATA_W-1:0] nonce_low_reg;
    logic [CFG_DATA_W-1:0] nonce_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_KEY_LOW:    key_low_reg    <= wr_data;
                REG_KEY_HIGH:   key_high_reg   <= wr_data;
                REG_NONCE_LOW:  nonce_low_reg  <= wr_data;
                REG_NONCE_HIGH: nonce_high_reg <= wr_data;
                default:        ;
            endcase
        end
    end

    // byte k of the restart image sits at bits 8k+7:8k
    assign load_state = {key_high_reg ^ nonce_high_reg, key_low_reg ^ nonce_low_reg};

endmodule

// ===== hw/rtl/sbks_keystream.sv =====
module sbks_keystream
    import sbks_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  sbks_ctrl_t         ctrl,
    input  byte_t              data_in,
    input  logic [STATE_W-1:0] load_state,
    output byte_t              data_out
);

    // slot k holds state[(position + k) mod 16]; the pair is slots 0 and 1 unless restarting
    byte_t rot_reg  [SLOT_COUNT];
    byte_t rot_next [SLOT_COUNT];
    byte_t pos_reg;
    byte_t pos_next;

    byte_t head;
    byte_t succ;
    byte_t pos_eff;
    byte_t sum;
    byte_t new_byte;

    always_comb
    begin
        head     = ctrl.restart ? load_state[BYTE_W-1:0] : rot_reg[0];
        succ     = ctrl.restart ? load_state[2*BYTE_W-1:BYTE_W] : rot_reg[1];
        pos_eff  = ctrl.restart ? '0 : pos_reg;
        sum      = head + succ + pos_eff;
        new_byte = SBOX[sum];
        data_out = data_in ^ new_byte ^ pos_eff;
        pos_next = pos_eff + 8'd1;
        for (int k = 0; k < SLOT_COUNT - 1; k++)
        begin
            rot_next[k] = ctrl.restart ? load_state[BYTE_W*(k+1) +: BYTE_W] : rot_reg[k+1];
        end
        rot_next[SLOT_COUNT-1] = new_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                rot_reg[k] <= '0;
            end
        end
        else if (ctrl.advance)
        begin
            pos_reg <= pos_next;
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                rot_reg[k] <= rot_next[k];
            end
        end
    end

endmodule

// ===== hw/rtl/sbox_keystream_byte_cipher_core.sv =====
// channel | handshake           | payload
// --------+---------------------+-----------------------------------
// in      | in_valid / in_ready   | data_byte[7:0], restart
// out     | out_valid / out_ready | out_byte[7:0]
// cfg     | cfg_valid / cfg_ready | cfg_index[7:0], cfg_data[63:0]
//
// one byte per cycle sustained while the output is not stalled; a request is captured
// in the input register and its result is registered in the output register on advance
// the throughput is set by the state update of the rotating slot line
// reset clears the cipher state, the position, the key and nonce registers
// a stalled output holds the input register; a new request is still taken
// whenever the input register is empty or drains in the same cycle
module sbox_keystream_byte_cipher_core
    import sbks_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  restart,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // input register
    logic  in_valid_reg;
    byte_t data_reg;
    logic  restart_reg;

    // output register
    logic  out_valid_reg;
    byte_t out_byte_reg;

    logic               advance;
    sbks_ctrl_t         ctrl;
    byte_t              step_byte;
    logic [STATE_W-1:0] load_state;

    // the request in the input register moves on when the output slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign cfg_ready = 1'b1;

    assign ctrl.advance = advance;
    assign ctrl.restart = restart_reg;

    sbks_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (cfg_valid && cfg_ready),
        .wr_index   (cfg_index),
        .wr_data    (cfg_data),
        .load_state (load_state)
    );

    sbks_keystream u_keystream (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .data_in    (data_reg),
        .load_state (load_state),
        .data_out   (step_byte)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // payload of the input register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg    <= data_byte;
            restart_reg <= restart;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= step_byte;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

endmodule
